// File: rtl/pps_pkg.sv
package pps_pkg;

  localparam int COORD_BITS = 16;
  localparam int FRAC_BITS  = 8;
  localparam int PT_BITS    = COORD_BITS + FRAC_BITS;
  localparam int DIST_BITS  = 26;
  localparam int D2_BITS    = 52;
  localparam int T_BITS     = 16;
  localparam int FIFO_DEPTH = 4;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] ax;
    logic signed [COORD_BITS-1:0] ay;
    logic signed [COORD_BITS-1:0] bx;
    logic signed [COORD_BITS-1:0] by;
    logic signed [PT_BITS-1:0]    px;
    logic signed [PT_BITS-1:0]    py;
    logic                         last;
  } edge_t;

endpackage

// File: rtl/pps_front.sv
module pps_front (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 vertex_valid,
  output logic                                 vertex_stall,
  input  logic signed [pps_pkg::PT_BITS-1:0]    point_x,
  input  logic signed [pps_pkg::PT_BITS-1:0]    point_y,
  input  logic signed [pps_pkg::COORD_BITS-1:0] vertex_x,
  input  logic signed [pps_pkg::COORD_BITS-1:0] vertex_y,
  input  logic                                 ring_end,
  input  logic                                 polygon_end,
  output logic                                 push,
  output pps_pkg::edge_t                       push_edge,
  input  logic                                 full
);
  import pps_pkg::*;

  logic ring_started;
  logic e0_pend;
  logic e1_pend;
  logic signed [COORD_BITS-1:0] first_x, first_y, prev_x, prev_y;
  logic signed [COORD_BITS-1:0] hv_x, hv_y, hp_x, hp_y, hf_x, hf_y;
  logic signed [PT_BITS-1:0]    hpx, hpy;
  logic                         hpend;
  logic                         accept;

  assign vertex_stall = e0_pend | e1_pend;
  assign accept       = vertex_valid & ~vertex_stall;
  assign push         = (e0_pend | e1_pend) & ~full;

  always_comb begin
    push_edge.px = hpx;
    push_edge.py = hpy;
    if (e0_pend) begin
      push_edge.ax   = hv_x;
      push_edge.ay   = hv_y;
      push_edge.bx   = hp_x;
      push_edge.by   = hp_y;
      push_edge.last = 1'b0;
    end else begin
      push_edge.ax   = hf_x;
      push_edge.ay   = hf_y;
      push_edge.bx   = hv_x;
      push_edge.by   = hv_y;
      push_edge.last = hpend;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ring_started <= 1'b0;
      e0_pend      <= 1'b0;
      e1_pend      <= 1'b0;
    end else if (accept) begin
      e0_pend      <= ring_started;
      e1_pend      <= ring_end | polygon_end;
      ring_started <= ~(ring_end | polygon_end);
    end else if (push) begin
      if (e0_pend) begin
        e0_pend <= 1'b0;
      end else begin
        e1_pend <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hv_x  <= vertex_x;
      hv_y  <= vertex_y;
      hp_x  <= prev_x;
      hp_y  <= prev_y;
      hpx   <= point_x;
      hpy   <= point_y;
      hpend <= polygon_end;
      prev_x <= vertex_x;
      prev_y <= vertex_y;
      if (ring_started) begin
        hf_x <= first_x;
        hf_y <= first_y;
      end else begin
        hf_x    <= vertex_x;
        hf_y    <= vertex_y;
        first_x <= vertex_x;
        first_y <= vertex_y;
      end
    end
  end

endmodule

// File: rtl/pps_fifo.sv
module pps_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  pps_pkg::edge_t push_edge,
  output logic           full,
  input  logic           pop,
  output pps_pkg::edge_t pop_edge,
  output logic           empty
);
  import pps_pkg::*;

  localparam int AW = $clog2(FIFO_DEPTH);
  localparam int CW = $clog2(FIFO_DEPTH + 1);

  edge_t           mem [FIFO_DEPTH];
  logic [AW-1:0]   wr_ptr;
  logic [AW-1:0]   rd_ptr;
  logic [CW-1:0]   count;

  assign full     = (count == CW'(FIFO_DEPTH));
  assign empty    = (count == '0);
  assign pop_edge = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_edge;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("edge queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("edge queue underflow");

endmodule

// File: rtl/pps_back.sv
module pps_back (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                empty,
  input  pps_pkg::edge_t                      pop_edge,
  output logic                                pop,
  output logic                                dist_valid,
  input  logic                                dist_stall,
  output logic signed [pps_pkg::DIST_BITS-1:0] signed_distance,
  output logic                                inside_res
);
  import pps_pkg::*;

  localparam int DW   = COORD_BITS + 1;
  localparam int UW   = PT_BITS + 1;
  localparam int QW   = PT_BITS + 2;
  localparam int MW   = PT_BITS + 3;
  localparam int PW   = 2 * MW;
  localparam int NW   = UW + DW + 1;
  localparam int DENW = 2 * DW + FRAC_BITS;
  localparam int CMPW = (NW > DENW + 1) ? NW : DENW + 1;
  localparam int RS   = T_BITS - FRAC_BITS;
  localparam logic signed [PW-1:0] HALF = (RS > 0) ? PW'(1) <<< (RS - 1) : '0;
  localparam logic [D2_BITS-1:0] MIN_INF = '1;
  localparam logic [DIST_BITS-1:0] DIST_MAX = {1'b0, {(DIST_BITS-1){1'b1}}};
  localparam int CNTW = $clog2(D2_BITS / 2 + 1);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_M0   = 4'd1;
  localparam logic [3:0] S_M1   = 4'd2;
  localparam logic [3:0] S_M2   = 4'd3;
  localparam logic [3:0] S_M3   = 4'd4;
  localparam logic [3:0] S_M4   = 4'd5;
  localparam logic [3:0] S_M5   = 4'd6;
  localparam logic [3:0] S_DEC  = 4'd7;
  localparam logic [3:0] S_DIV  = 4'd8;
  localparam logic [3:0] S_Q0   = 4'd9;
  localparam logic [3:0] S_Q1   = 4'd10;
  localparam logic [3:0] S_E0   = 4'd11;
  localparam logic [3:0] S_E1   = 4'd12;
  localparam logic [3:0] S_MIN  = 4'd13;
  localparam logic [3:0] S_SQ   = 4'd14;
  localparam logic [3:0] S_FIN  = 4'd15;

  function automatic logic signed [UW-1:0] scl(input logic signed [COORD_BITS-1:0] v);
    scl = UW'(v) <<< FRAC_BITS;
  endfunction

  logic [3:0]              state;
  edge_t                   e;
  logic signed [UW-1:0]    uxa, uya;
  logic signed [DW-1:0]    dx, dy;
  logic signed [PW-1:0]    lhs, rhs;
  logic signed [NW-1:0]    num;
  logic [DENW-1:0]         den;
  logic                    cross_chk;
  logic [T_BITS-1:0]       t;
  logic [DENW:0]           rem;
  logic [CNTW-1:0]         cnt;
  logic signed [QW-1:0]    qx, qy;
  logic [PW:0]             d2;
  logic [D2_BITS-1:0]      min_d2;
  logic                    parity;
  logic [D2_BITS-1:0]      sn, sr, sb;

  logic signed [MW-1:0]    mul_a, mul_b;
  logic signed [PW-1:0]    prod;
  logic [DENW-1:0]         den8;
  logic [DENW:0]           rem2;
  logic                    rem_ge;
  logic signed [QW-1:0]    qprj;
  logic signed [MW-1:0]    ex, ey;
  logic [D2_BITS-1:0]      d2_sat;
  logic [D2_BITS-1:0]      new_min;
  logic [D2_BITS-1:0]      sq_sum;
  logic [DIST_BITS-1:0]    mag;
  logic                    out_free;

  assign pop      = (state == S_IDLE) && !empty;
  assign den8     = den << FRAC_BITS;
  assign rem2     = rem << 1;
  assign rem_ge   = rem2 >= {1'b0, den8};
  assign prod     = mul_a * mul_b;
  assign qprj     = QW'((prod + HALF) >>> RS);
  assign ex       = MW'(e.px) - MW'(qx);
  assign ey       = MW'(e.py) - MW'(qy);
  assign d2_sat   = (d2 > (PW+1)'(MIN_INF)) ? MIN_INF : d2[D2_BITS-1:0];
  assign new_min  = (d2_sat < min_d2) ? d2_sat : min_d2;
  assign sq_sum   = sr + sb;
  assign mag      = (sr > D2_BITS'(DIST_MAX)) ? DIST_MAX : sr[DIST_BITS-1:0];
  assign out_free = !dist_valid || !dist_stall;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_M0: begin mul_a = MW'(uxa); mul_b = MW'(dy); end
      S_M1: begin mul_a = MW'(dx);  mul_b = MW'(uya); end
      S_M2: begin mul_a = MW'(uxa); mul_b = MW'(dx); end
      S_M3: begin mul_a = MW'(uya); mul_b = MW'(dy); end
      S_M4: begin mul_a = MW'(dx);  mul_b = MW'(dx); end
      S_M5: begin mul_a = MW'(dy);  mul_b = MW'(dy); end
      S_Q0: begin mul_a = MW'(dx);  mul_b = MW'($signed({1'b0, t})); end
      S_Q1: begin mul_a = MW'(dy);  mul_b = MW'($signed({1'b0, t})); end
      S_E0: begin mul_a = ex;       mul_b = ex; end
      S_E1: begin mul_a = ey;       mul_b = ey; end
      default: begin mul_a = '0;    mul_b = '0; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      parity     <= 1'b0;
      min_d2     <= MIN_INF;
      dist_valid <= 1'b0;
      cnt        <= '0;
    end else begin
      if (state == S_FIN && out_free) begin
        dist_valid <= 1'b1;
      end else if (dist_valid && !dist_stall) begin
        dist_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (!empty) begin
            e         <= pop_edge;
            uxa       <= UW'(pop_edge.px) - scl(pop_edge.ax);
            uya       <= UW'(pop_edge.py) - scl(pop_edge.ay);
            dx        <= DW'(pop_edge.bx) - DW'(pop_edge.ax);
            dy        <= DW'(pop_edge.by) - DW'(pop_edge.ay);
            cross_chk <= (scl(pop_edge.ay) > UW'(pop_edge.py)) !=
                         (scl(pop_edge.by) > UW'(pop_edge.py));
            state     <= S_M0;
          end
        end
        S_M0: begin lhs <= prod; state <= S_M1; end
        S_M1: begin rhs <= prod; state <= S_M2; end
        S_M2: begin num <= NW'(prod); state <= S_M3; end
        S_M3: begin
          num <= num + NW'(prod);
          if (cross_chk && ((dy > 0) ? (lhs < rhs) : (lhs > rhs))) begin
            parity <= ~parity;
          end
          state <= S_M4;
        end
        S_M4: begin den <= prod[DENW-1:0]; state <= S_M5; end
        S_M5: begin den <= den + prod[DENW-1:0]; state <= S_DEC; end
        S_DEC: begin
          if (dx == '0 && dy == '0) begin
            qx    <= QW'(scl(e.ax));
            qy    <= QW'(scl(e.ay));
            state <= S_E0;
          end else if (CMPW'(num) >= CMPW'($signed({1'b0, den8}))) begin
            qx    <= QW'(scl(e.bx));
            qy    <= QW'(scl(e.by));
            state <= S_E0;
          end else if (num > 0) begin
            rem   <= (DENW+1)'(num);
            t     <= '0;
            cnt   <= '0;
            state <= S_DIV;
          end else begin
            qx    <= QW'(scl(e.ax));
            qy    <= QW'(scl(e.ay));
            state <= S_E0;
          end
        end
        S_DIV: begin
          rem <= rem_ge ? rem2 - {1'b0, den8} : rem2;
          t   <= {t[T_BITS-2:0], rem_ge};
          cnt <= cnt + 1'b1;
          if (cnt == CNTW'(T_BITS - 1)) begin
            state <= S_Q0;
          end
        end
        S_Q0: begin qx <= QW'(scl(e.ax)) + qprj; state <= S_Q1; end
        S_Q1: begin qy <= QW'(scl(e.ay)) + qprj; state <= S_E0; end
        S_E0: begin d2 <= (PW+1)'(prod); state <= S_E1; end
        S_E1: begin d2 <= d2 + (PW+1)'(prod); state <= S_MIN; end
        S_MIN: begin
          min_d2 <= new_min;
          if (e.last) begin
            sn    <= new_min;
            sr    <= '0;
            sb    <= D2_BITS'(1) << (D2_BITS - 2);
            cnt   <= '0;
            state <= S_SQ;
          end else begin
            state <= S_IDLE;
          end
        end
        S_SQ: begin
          if (sn >= sq_sum) begin
            sn <= sn - sq_sum;
            sr <= (sr >> 1) + sb;
          end else begin
            sr <= sr >> 1;
          end
          sb  <= sb >> 2;
          cnt <= cnt + 1'b1;
          if (cnt == CNTW'(D2_BITS / 2 - 1)) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (out_free) begin
            inside_res <= parity;
            if (min_d2 == MIN_INF) begin
              signed_distance <= -$signed(DIST_MAX);
            end else begin
              signed_distance <= parity ? $signed(mag) : -$signed(mag);
            end
            parity <= 1'b0;
            min_d2 <= MIN_INF;
            state  <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_min_monotone: assert property (@(posedge clk) disable iff (rst)
    (state != S_FIN) |=> (min_d2 <= $past(min_d2)))
    else $error("minimum distance grew within a polygon");

endmodule

// File: rtl/point_polygon_signed_distance.sv
// channel  | handshake                 | payload
// vertex   | vertex_valid/vertex_stall | point_x point_y vertex_x vertex_y ring_end polygon_end
// dist     | dist_valid/dist_stall     | signed_distance inside_res
//
// A vertex request is accepted while vertex_stall is low; each edge it forms then holds vertex_stall
// while it enters the queue. The distance unit works on one edge at a time and runs the projection
// divide (16 steps) when the projection falls strictly inside the edge; polygon end adds a square root.
// rst is synchronous and clears the ring, parity and minimum state.
// A 4-entry edge queue lets vertex intake run ahead while the distance unit is busy.
// The result sits in an output register until taken; only the next result waits on it.
module point_polygon_signed_distance (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  vertex_valid,
  output logic                                  vertex_stall,
  input  logic signed [pps_pkg::PT_BITS-1:0]     point_x,
  input  logic signed [pps_pkg::PT_BITS-1:0]     point_y,
  input  logic signed [pps_pkg::COORD_BITS-1:0]  vertex_x,
  input  logic signed [pps_pkg::COORD_BITS-1:0]  vertex_y,
  input  logic                                  ring_end,
  input  logic                                  polygon_end,
  output logic                                  dist_valid,
  input  logic                                  dist_stall,
  output logic signed [pps_pkg::DIST_BITS-1:0]   signed_distance,
  output logic                                  inside_res
);
  import pps_pkg::*;

  logic  push, full, pop, empty;
  edge_t push_edge, pop_edge;

  pps_front u_front (
    .clk          (clk),
    .rst          (rst),
    .vertex_valid (vertex_valid),
    .vertex_stall (vertex_stall),
    .point_x      (point_x),
    .point_y      (point_y),
    .vertex_x     (vertex_x),
    .vertex_y     (vertex_y),
    .ring_end     (ring_end),
    .polygon_end  (polygon_end),
    .push         (push),
    .push_edge    (push_edge),
    .full         (full)
  );

  pps_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_edge (push_edge),
    .full      (full),
    .pop       (pop),
    .pop_edge  (pop_edge),
    .empty     (empty)
  );

  pps_back u_back (
    .clk             (clk),
    .rst             (rst),
    .empty           (empty),
    .pop_edge        (pop_edge),
    .pop             (pop),
    .dist_valid      (dist_valid),
    .dist_stall      (dist_stall),
    .signed_distance (signed_distance),
    .inside_res      (inside_res)
  );

endmodule
